### rtl/lbf_pkg.sv
// Package of shared constants, types and the level step function for the fade engine.
`default_nettype none
package lbf_pkg;

    // Channel count and the widths that follow from it.
    localparam int CHANNELS = 4;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(CHANNELS + 1);

    // Field widths fixed by the interface.
    localparam int CH_W    = 2;
    localparam int OP_W    = 2;
    localparam int PCT_W   = 8;
    localparam int LEVEL_W = 16;
    localparam int STEP_W  = 10;
    localparam int CMP_W   = CH_W + CNT_W;

    // Configuration port geometry.
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TOP_LEVEL    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM_LEVEL = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_LEVEL  = 2'd3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_FIXED = 2'd2;

    // Reset values.
    localparam logic [STEP_W-1:0]  STEP_SIZE_RESET = 10'd20;
    localparam logic [LEVEL_W-1:0] TOP_RESET       = 16'd900;
    localparam logic [LEVEL_W-1:0] BOTTOM_RESET    = 16'd20;
    localparam logic [LEVEL_W-1:0] START_RESET     = 16'd20;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET     = 16'd20;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [LEVEL_W-1:0] top_level;
        logic [LEVEL_W-1:0] bottom_level;
        logic [LEVEL_W-1:0] start_level;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_start;
        logic             capture;
        logic             scan_emit;
        logic             fix_emit;
        logic [IDX_W-1:0] ch;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CHANNELS-1:0] fading;
        logic                out_free;
    } status_t;

    // Result of one level step.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               falling;
    } step_t;

    // One triangle-wave step: move the level and turn at the limits.
    function automatic step_t lbf_step(
        input logic [LEVEL_W-1:0] level,
        input logic               falling,
        input cfg_t               cfg
    );
        step_t res;
        res.falling = falling;
        if (!falling) begin
            res.level = level + LEVEL_W'(cfg.step_size);
            if (res.level > cfg.top_level) begin
                res.falling = 1'b1;
            end
        end else begin
            res.level = level - LEVEL_W'(cfg.step_size);
            if (res.level <= cfg.bottom_level) begin
                res.falling = 1'b0;
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/led_breathing_fade_engine.sv
// Top level of the breathing LED fade engine: register bank, controller and datapath.
// A result beat is registered and appears the cycle after the scan visits its channel.
// A tick closes the input while the scan visits each channel, and a fixed-level
// command until its beat is loaded, after any output stall; a start keeps it open.
// The scan, one channel per cycle via one step unit unless stalled, sets tick time.
// Reset (synchronous, active low) sets levels to 20, stops fading, clears the output.
`default_nettype none
module led_breathing_fade_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lbf_pkg::OP_W-1:0]      s_operation,
    input  wire logic [lbf_pkg::CH_W-1:0]      s_channel,
    input  wire logic [lbf_pkg::PCT_W-1:0]     s_fixed_percent,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [lbf_pkg::CH_W-1:0]      m_out_channel,
    output logic      [lbf_pkg::LEVEL_W-1:0]   m_compare_value,
    output logic                               m_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lbf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lbf_pkg::DATA_W-1:0]    pwdata,
    output logic      [lbf_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    lbf_pkg::cfg_t    cfg;
    lbf_pkg::cmd_t    cmd;
    lbf_pkg::status_t status;

    // Configuration registers.
    lbf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing of operations.
    lbf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_channel   (s_channel),
        .status      (status),
        .cmd         (cmd)
    );

    // Channel state and result register.
    lbf_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_fixed_percent (s_fixed_percent),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_channel   (m_out_channel),
        .m_compare_value (m_compare_value),
        .m_last          (m_last)
    );

endmodule
`default_nettype wire

### rtl/lbf_regs.sv
// Configuration register bank behind the APB-style port.
`default_nettype none
module lbf_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lbf_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lbf_pkg::DATA_W-1:0]    pwdata,
    output logic      [lbf_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output lbf_pkg::cfg_t                      cfg
);

    lbf_pkg::cfg_t                       cfg_reg;
    logic [lbf_pkg::REG_IDX_W-1:0]       reg_idx;
    logic                                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lbf_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes on the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size    <= lbf_pkg::STEP_SIZE_RESET;
            cfg_reg.top_level    <= lbf_pkg::TOP_RESET;
            cfg_reg.bottom_level <= lbf_pkg::BOTTOM_RESET;
            cfg_reg.start_level  <= lbf_pkg::START_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                lbf_pkg::REG_STEP_SIZE: begin
                    cfg_reg.step_size <= pwdata[lbf_pkg::STEP_W-1:0];
                end
                lbf_pkg::REG_TOP_LEVEL: begin
                    cfg_reg.top_level <= pwdata[lbf_pkg::LEVEL_W-1:0];
                end
                lbf_pkg::REG_BOTTOM_LEVEL: begin
                    cfg_reg.bottom_level <= pwdata[lbf_pkg::LEVEL_W-1:0];
                end
                lbf_pkg::REG_START_LEVEL: begin
                    cfg_reg.start_level <= pwdata[lbf_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_idx)
            lbf_pkg::REG_STEP_SIZE:    prdata = lbf_pkg::DATA_W'(cfg_reg.step_size);
            lbf_pkg::REG_TOP_LEVEL:    prdata = lbf_pkg::DATA_W'(cfg_reg.top_level);
            lbf_pkg::REG_BOTTOM_LEVEL: prdata = lbf_pkg::DATA_W'(cfg_reg.bottom_level);
            lbf_pkg::REG_START_LEVEL:  prdata = lbf_pkg::DATA_W'(cfg_reg.start_level);
            default:                   prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/lbf_ctrl.sv
// Controller state machine that sequences ticks, start and fixed-level commands.
`default_nettype none
module lbf_ctrl (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [lbf_pkg::OP_W-1:0]       s_operation,
    input  wire logic [lbf_pkg::CH_W-1:0]       s_channel,
    input  lbf_pkg::status_t                    status,
    output lbf_pkg::cmd_t                       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [lbf_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                        accept;
    logic                        ch_ok;
    logic                        idx_at_end;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign ch_ok      = (lbf_pkg::CMP_W'(s_channel) < lbf_pkg::CMP_W'(lbf_pkg::CHANNELS));
    assign idx_at_end = (idx_reg == lbf_pkg::IDX_W'(lbf_pkg::CHANNELS - 1));

    // Next-state and command decode.
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd.load_start = 1'b0;
        cmd.capture    = 1'b0;
        cmd.scan_emit  = 1'b0;
        cmd.fix_emit   = 1'b0;
        cmd.ch         = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.ch = lbf_pkg::IDX_W'(s_channel);
                if (accept) begin
                    case (s_operation)
                        lbf_pkg::OP_TICK: begin
                            state_next = ST_SCAN;
                            idx_next   = '0;
                        end
                        lbf_pkg::OP_START: begin
                            cmd.load_start = ch_ok;
                        end
                        lbf_pkg::OP_FIXED: begin
                            if (ch_ok) begin
                                cmd.capture = 1'b1;
                                state_next  = ST_FIX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // A fading channel waits for the output register; others are skipped.
                if (!status.fading[idx_reg] || status.out_free) begin
                    cmd.scan_emit = status.fading[idx_reg];
                    if (idx_at_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + lbf_pkg::IDX_W'(1);
                    end
                end
            end
            ST_FIX: begin
                if (status.out_free) begin
                    cmd.fix_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire

### rtl/lbf_datapath.sv
// Datapath holding channel levels, directions, fading flags and the output register.
`default_nettype none
module lbf_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [lbf_pkg::PCT_W-1:0]       s_fixed_percent,
    input  lbf_pkg::cfg_t                        cfg,
    input  lbf_pkg::cmd_t                        cmd,
    output lbf_pkg::status_t                     status,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [lbf_pkg::CH_W-1:0]        m_out_channel,
    output logic      [lbf_pkg::LEVEL_W-1:0]     m_compare_value,
    output logic                                 m_last
);

    logic [lbf_pkg::LEVEL_W-1:0]  level_reg [lbf_pkg::CHANNELS];
    logic [lbf_pkg::CHANNELS-1:0] fading_reg;
    logic [lbf_pkg::CHANNELS-1:0] falling_reg;
    logic [lbf_pkg::IDX_W-1:0]    cap_ch_reg;
    logic [lbf_pkg::PCT_W-1:0]    cap_pct_reg;

    logic                         out_valid_reg;
    logic [lbf_pkg::CH_W-1:0]     out_ch_reg;
    logic [lbf_pkg::LEVEL_W-1:0]  out_val_reg;
    logic                         out_last_reg;

    logic [lbf_pkg::LEVEL_W-1:0]  pct10;
    logic [lbf_pkg::IDX_W-1:0]    sel_ch;
    logic [lbf_pkg::LEVEL_W-1:0]  sel_level;
    lbf_pkg::step_t               stepped;
    logic                         higher_fading;

    assign status.fading   = fading_reg;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid         = out_valid_reg;
    assign m_out_channel   = out_ch_reg;
    assign m_compare_value = out_val_reg;
    assign m_last          = out_last_reg;

    // Fixed level is the percentage times ten, formed as times eight plus times two.
    assign pct10 = (lbf_pkg::LEVEL_W'(cap_pct_reg) << 3) + (lbf_pkg::LEVEL_W'(cap_pct_reg) << 1);

    // One shared step unit, fed either by a scanned channel or by the fixed level.
    assign sel_ch    = cmd.fix_emit ? cap_ch_reg : cmd.ch;
    assign sel_level = cmd.fix_emit ? pct10 : level_reg[cmd.ch];
    assign stepped   = lbf_pkg::lbf_step(sel_level, falling_reg[sel_ch], cfg);

    // Whether a later channel in the scan is still fading, which decides the last flag.
    always_comb begin
        higher_fading = 1'b0;
        for (int j = 0; j < lbf_pkg::CHANNELS; j++) begin
            if (fading_reg[j] && (lbf_pkg::IDX_W'(j) > cmd.ch)) begin
                higher_fading = 1'b1;
            end
        end
    end

    // Channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lbf_pkg::CHANNELS; i++) begin
                level_reg[i] <= lbf_pkg::LEVEL_RESET;
            end
            fading_reg  <= '0;
            falling_reg <= '0;
        end else begin
            if (cmd.load_start) begin
                level_reg[cmd.ch]  <= cfg.start_level;
                fading_reg[cmd.ch] <= 1'b1;
            end
            if (cmd.scan_emit || cmd.fix_emit) begin
                level_reg[sel_ch]   <= stepped.level;
                falling_reg[sel_ch] <= stepped.falling;
            end
            if (cmd.fix_emit) begin
                fading_reg[sel_ch] <= 1'b0;
            end
        end
    end

    // Operands of a fixed-level command, held until the output register is free.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cap_ch_reg  <= cmd.ch;
            cap_pct_reg <= s_fixed_percent;
        end
    end

    // Output register: a beat is loaded when the slot is free and held until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.scan_emit || cmd.fix_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_emit || cmd.fix_emit) begin
            out_ch_reg   <= lbf_pkg::CH_W'(sel_ch);
            out_val_reg  <= sel_level;
            out_last_reg <= cmd.fix_emit || !higher_fading;
        end
    end

endmodule
`default_nettype wire

### rtl/lbf_checker.sv
// Port-level assertion checker for the fade engine and its bind statement.
`default_nettype none
module lbf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [lbf_pkg::OP_W-1:0]      s_operation,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [lbf_pkg::CH_W-1:0]      m_out_channel,
    input wire logic [lbf_pkg::LEVEL_W-1:0]   m_compare_value,
    input wire logic                          m_last
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_compare_value)
            && $stable(m_out_channel) && $stable(m_last))
        else $error("result beat changed while stalled");

    // A tick or fixed-level beat keeps the input closed on the following cycle.
    a_busy_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready
            && (s_operation == lbf_pkg::OP_TICK || s_operation == lbf_pkg::OP_FIXED)
        |=> !s_ready)
        else $error("input reopened during a tick or fixed-level command");

    // A start command produces no result beat.
    a_start_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == lbf_pkg::OP_START && !m_valid |=> !m_valid)
        else $error("start command produced a result");

    // Once the input is open again, any beat still waiting closes its command.
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && s_ready |-> m_last)
        else $error("pending result is not the last of its command while idle");

endmodule

bind led_breathing_fade_engine lbf_checker u_lbf_checker (.*);
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the breathing LED fade engine, with a built-in level predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The unused operation code, which the block must ignore.
    localparam logic [lbf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    // Cycles allowed for a tick's scan to finish once no result is outstanding.
    localparam int SCAN_SLACK = 2 * lbf_pkg::CHANNELS + 4;
    // Length of the long receiver hold-off that makes the block back up.
    localparam int HOLD_CYCLES = 80;

    // One compare-value beat on the result channel.
    typedef struct packed {
        logic [lbf_pkg::CH_W-1:0]    ch;
        logic [lbf_pkg::LEVEL_W-1:0] value;
        logic                        last;
    } compare_beat_t;

    // One row of the directed stimulus; typed rows carry their own expectation.
    typedef struct packed {
        logic [lbf_pkg::OP_W-1:0]    op;
        logic [lbf_pkg::CH_W-1:0]    ch;
        logic [lbf_pkg::PCT_W-1:0]   pct;
        logic                        typed;
        logic [2:0]                  beats;
        logic [lbf_pkg::LEVEL_W-1:0] value;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [lbf_pkg::OP_W-1:0]      s_operation;
    logic [lbf_pkg::CH_W-1:0]      s_channel;
    logic [lbf_pkg::PCT_W-1:0]     s_fixed_percent;
    logic                          m_valid;
    logic                          m_ready;
    logic [lbf_pkg::CH_W-1:0]      m_out_channel;
    logic [lbf_pkg::LEVEL_W-1:0]   m_compare_value;
    logic                          m_last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [lbf_pkg::ADDR_W-1:0]    paddr;
    logic [lbf_pkg::DATA_W-1:0]    pwdata;
    logic [lbf_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    // Expectation carried alongside the beat on offer.
    logic                          item_typed;
    logic [2:0]                    item_beats;
    logic [lbf_pkg::LEVEL_W-1:0]   item_value;

    // Predicted state of the engine.
    lbf_pkg::cfg_t                 model_cfg;
    logic [lbf_pkg::LEVEL_W-1:0]   model_level   [lbf_pkg::CHANNELS];
    logic                          model_fading  [lbf_pkg::CHANNELS];
    logic                          model_falling [lbf_pkg::CHANNELS];
    compare_beat_t                 cmd_beats [$];
    compare_beat_t                 awaited_beats [$];
    compare_beat_t                 want_beat;

    int                            mismatches = 0;
    bit                            steady = 0;
    bit                            hold_request = 0;

    led_breathing_fade_engine dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_channel       (s_channel),
        .s_fixed_percent (s_fixed_percent),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_channel   (m_out_channel),
        .m_compare_value (m_compare_value),
        .m_last          (m_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Directed stimulus under the reset configuration.
    stim_row_t directed_rows [0:21] = '{
        '{lbf_pkg::OP_TICK,  2'd0, 8'd0,   1'b1, 3'd0, 16'd0},
        '{OP_UNUSED,         2'd3, 8'd255, 1'b1, 3'd0, 16'd0},
        '{lbf_pkg::OP_FIXED, 2'd0, 8'd0,   1'b1, 3'd1, 16'd0},
        '{lbf_pkg::OP_FIXED, 2'd3, 8'd255, 1'b1, 3'd1, 16'd2550},
        '{lbf_pkg::OP_FIXED, 2'd1, 8'd90,  1'b1, 3'd1, 16'd900},
        '{lbf_pkg::OP_START, 2'd0, 8'd0,   1'b1, 3'd0, 16'd0},
        '{lbf_pkg::OP_START, 2'd1, 8'd0,   1'b1, 3'd0, 16'd0},
        '{lbf_pkg::OP_TICK,  2'd0, 8'd0,   1'b0, 3'd0, 16'd0},
        '{lbf_pkg::OP_START, 2'd2, 8'd0,   1'b1, 3'd0, 16'd0},
        '{lbf_pkg::OP_START, 2'd3, 8'd0,   1'b1, 3'd0, 16'd0},
        '{lbf_pkg::OP_TICK,  2'd0, 8'd0,   1'b0, 3'd0, 16'd0},
        '{lbf_pkg::OP_TICK,  2'd1, 8'd17,  1'b0, 3'd0, 16'd0},
        '{lbf_pkg::OP_TICK,  2'd2, 8'd0,   1'b0, 3'd0, 16'd0},
        '{lbf_pkg::OP_TICK,  2'd3, 8'd255, 1'b0, 3'd0, 16'd0},
        '{lbf_pkg::OP_FIXED, 2'd2, 8'd170, 1'b1, 3'd1, 16'd1700},
        '{lbf_pkg::OP_FIXED, 2'd1, 8'd85,  1'b1, 3'd1, 16'd850},
        '{lbf_pkg::OP_TICK,  2'd0, 8'd0,   1'b0, 3'd0, 16'd0},
        '{OP_UNUSED,         2'd0, 8'd0,   1'b1, 3'd0, 16'd0},
        '{lbf_pkg::OP_TICK,  2'd0, 8'd0,   1'b0, 3'd0, 16'd0},
        '{lbf_pkg::OP_START, 2'd2, 8'd0,   1'b1, 3'd0, 16'd0},
        '{lbf_pkg::OP_TICK,  2'd0, 8'd0,   1'b0, 3'd0, 16'd0},
        '{lbf_pkg::OP_TICK,  2'd0, 8'd0,   1'b0, 3'd0, 16'd0}
    };

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #400000;
        $display("testbench NOT OK");
        $finish;
    end

    // Move one channel a step along its triangle wave.
    function automatic void triangle_step(input int ch);
        if (!model_falling[ch]) begin
            model_level[ch] = model_level[ch] + lbf_pkg::LEVEL_W'(model_cfg.step_size);
            if (model_level[ch] > model_cfg.top_level) begin
                model_falling[ch] = 1'b1;
            end
        end else begin
            model_level[ch] = model_level[ch] - lbf_pkg::LEVEL_W'(model_cfg.step_size);
            if (model_level[ch] <= model_cfg.bottom_level) begin
                model_falling[ch] = 1'b0;
            end
        end
    endfunction

    // Apply one accepted command to the predicted state and collect its beats.
    function automatic void apply_command(input logic [lbf_pkg::OP_W-1:0] op,
                                          input logic [lbf_pkg::CH_W-1:0] ch,
                                          input logic [lbf_pkg::PCT_W-1:0] pct);
        compare_beat_t b;
        cmd_beats.delete();
        if (op == lbf_pkg::OP_TICK) begin
            for (int i = 0; i < lbf_pkg::CHANNELS; i++) begin
                if (model_fading[i]) begin
                    b.ch    = lbf_pkg::CH_W'(i);
                    b.value = model_level[i];
                    b.last  = 1'b0;
                    cmd_beats.push_back(b);
                    triangle_step(i);
                end
            end
            if (cmd_beats.size() != 0) begin
                cmd_beats[cmd_beats.size() - 1].last = 1'b1;
            end
        end else if (op == lbf_pkg::OP_START && int'(ch) < lbf_pkg::CHANNELS) begin
            model_level[ch]  = model_cfg.start_level;
            model_fading[ch] = 1'b1;
        end else if (op == lbf_pkg::OP_FIXED && int'(ch) < lbf_pkg::CHANNELS) begin
            model_fading[ch] = 1'b0;
            model_level[ch]  = lbf_pkg::LEVEL_W'(pct) * lbf_pkg::LEVEL_W'(10);
            b.ch    = ch;
            b.value = model_level[ch];
            b.last  = 1'b1;
            cmd_beats.push_back(b);
            triangle_step(int'(ch));
        end
    endfunction

    // Predict on every accepted command, then check every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            apply_command(s_operation, s_channel, s_fixed_percent);
            if (item_typed) begin
                for (int k = 0; k < int'(item_beats); k++) begin
                    awaited_beats.push_back('{ch: s_channel, value: item_value, last: 1'b1});
                end
            end else begin
                foreach (cmd_beats[k]) begin
                    awaited_beats.push_back(cmd_beats[k]);
                end
            end
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_beats.size() == 0) begin
                $error("unexpected beat: channel %0d value %0d last %0d",
                       m_out_channel, m_compare_value, m_last);
                mismatches++;
            end else begin
                want_beat = awaited_beats.pop_front();
                if (m_out_channel !== want_beat.ch) begin
                    $error("out_channel: expected %0d, got %0d", want_beat.ch, m_out_channel);
                    mismatches++;
                end
                if (m_compare_value !== want_beat.value) begin
                    $error("compare_value: expected %0d, got %0d",
                           want_beat.value, m_compare_value);
                    mismatches++;
                end
                if (m_last !== want_beat.last) begin
                    $error("last: expected %0d, got %0d", want_beat.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off when asked for.
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Offer one command beat and hold it until the block takes it.
    task automatic send_item(input logic [lbf_pkg::OP_W-1:0] op,
                             input logic [lbf_pkg::CH_W-1:0] ch,
                             input logic [lbf_pkg::PCT_W-1:0] pct, input logic typed,
                             input logic [2:0] beats,
                             input logic [lbf_pkg::LEVEL_W-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_channel       <= ch;
        s_fixed_percent <= pct;
        item_typed      <= typed;
        item_beats      <= beats;
        item_value      <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // A random command, mostly ticks and starts so that channels keep fading.
    task automatic send_random();
        int pick;
        logic [lbf_pkg::OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            op = lbf_pkg::OP_TICK;
        end else if (pick < 73) begin
            op = lbf_pkg::OP_START;
        end else if (pick < 95) begin
            op = lbf_pkg::OP_FIXED;
        end else begin
            op = OP_UNUSED;
        end
        send_item(op, lbf_pkg::CH_W'($urandom_range(0, 3)),
                  lbf_pkg::PCT_W'($urandom_range(0, 255)), 1'b0, 3'd0, '0);
    endtask

    // Stop offering beats and wait until the block has gone quiet.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_beats.size() != 0) @(posedge aclk);
        repeat (SCAN_SLACK) @(posedge aclk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [lbf_pkg::REG_IDX_W-1:0] idx,
                             input logic [lbf_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lbf_pkg::REG_STEP_SIZE:    model_cfg.step_size    = value[lbf_pkg::STEP_W-1:0];
            lbf_pkg::REG_TOP_LEVEL:    model_cfg.top_level    = value[lbf_pkg::LEVEL_W-1:0];
            lbf_pkg::REG_BOTTOM_LEVEL: model_cfg.bottom_level = value[lbf_pkg::LEVEL_W-1:0];
            lbf_pkg::REG_START_LEVEL:  model_cfg.start_level  = value[lbf_pkg::LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // Every channel fading, then a burst of ticks against a receiver that holds off.
    task automatic squeeze();
        steady = 1;
        for (int i = 0; i < lbf_pkg::CHANNELS; i++) begin
            send_item(lbf_pkg::OP_START, lbf_pkg::CH_W'(i), '0, 1'b0, 3'd0, '0);
        end
        hold_request = 1;
        repeat (16) send_item(lbf_pkg::OP_TICK, '0, '0, 1'b0, 3'd0, '0);
        steady = 0;
    endtask

    // Reprogram all four registers while idle, then run random commands and, if asked, a squeeze.
    task automatic run_phase(input int step, input int top, input int bottom,
                             input int start, input int count, input bit with_squeeze);
        settle();
        write_reg(lbf_pkg::REG_STEP_SIZE, lbf_pkg::DATA_W'(step));
        write_reg(lbf_pkg::REG_TOP_LEVEL, lbf_pkg::DATA_W'(top));
        write_reg(lbf_pkg::REG_BOTTOM_LEVEL, lbf_pkg::DATA_W'(bottom));
        write_reg(lbf_pkg::REG_START_LEVEL, lbf_pkg::DATA_W'(start));
        for (int k = 0; k < count; k++) begin
            steady = (k >= 12 && k < 20);
            send_random();
        end
        steady = 0;
        if (with_squeeze) begin
            squeeze();
        end
    endtask

    // Main sequence.
    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_operation     <= '0;
        s_channel       <= '0;
        s_fixed_percent <= '0;
        item_typed      <= 1'b0;
        item_beats      <= '0;
        item_value      <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;

        // Predicted state after reset.
        model_cfg.step_size    = lbf_pkg::STEP_SIZE_RESET;
        model_cfg.top_level    = lbf_pkg::TOP_RESET;
        model_cfg.bottom_level = lbf_pkg::BOTTOM_RESET;
        model_cfg.start_level  = lbf_pkg::START_RESET;
        for (int i = 0; i < lbf_pkg::CHANNELS; i++) begin
            model_level[i]   = lbf_pkg::LEVEL_RESET;
            model_fading[i]  = 1'b0;
            model_falling[i] = 1'b0;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].op, directed_rows[r].ch, directed_rows[r].pct,
                      directed_rows[r].typed, directed_rows[r].beats, directed_rows[r].value);
        end

        // Random phases: reset values, widest values, narrowest values, zero step, typical.
        run_phase(20, 900, 20, 20, 50, 1'b1);
        run_phase(1023, 65535, 0, 65535, 45, 1'b0);
        run_phase(1, 0, 65535, 0, 45, 1'b1);
        run_phase(0, 500, 100, 300, 35, 1'b0);
        run_phase(37, 1200, 300, 700, 45, 1'b0);

        settle();
        if (awaited_beats.size() != 0) begin
            $error("%0d expected beats never arrived", awaited_beats.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
rtl/lbf_pkg.sv
rtl/lbf_regs.sv
rtl/lbf_ctrl.sv
rtl/lbf_datapath.sv
rtl/led_breathing_fade_engine.sv
rtl/lbf_checker.sv
verif/testbench.sv
